@@ hdl/http_chunked_body_decoder_defines.svh @@
// Assertion macros used by the checker file of the chunked body decoder.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication
`define HCBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hcbd_pkg.sv @@
// Package of the chunked body decoder: widths, character codes, status codes
// and character class functions. No dependencies.
package hcbd_pkg;

    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 48;
    localparam int STAT_W           = 2;
    localparam int LINE_BYTES_DEF   = 128;
    localparam int MAX_TRAILERS_DEF = 32;

    localparam logic [STAT_W-1:0] ST_MORE = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAIL = 2'd2;

    localparam logic [BYTE_W-1:0] CHR_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_SP     = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CHR_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CHR_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CHR_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CHR_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHR_DEL    = 8'h7F;

    function automatic logic is_tok(input logic [BYTE_W-1:0] c);
        logic r;
        r = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
            (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                       8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
        return r;
    endfunction

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == CHR_SP) || (c == CHR_TAB);
    endfunction

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic line_byte_bad(input logic [BYTE_W-1:0] c);
        return ((c < CHR_SP) && (c != CHR_TAB)) || (c >= CHR_DEL);
    endfunction

endpackage

@@ hdl/hcbd_if.sv @@
// Channel interfaces of the chunked body decoder: raw byte in, result out,
// expected length write. Depends on hcbd_pkg.
interface hcbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [hcbd_pkg::BYTE_W-1:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface hcbd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        data_valid;
    logic [hcbd_pkg::BYTE_W-1:0] data_byte;
    logic [hcbd_pkg::STAT_W-1:0] status;
    modport source (output valid, output data_valid, output data_byte, output status,
                    input ready);
    modport sink   (input valid, input data_valid, input data_byte, input status,
                    output ready);
endinterface

interface hcbd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [hcbd_pkg::LEN_W-1:0] expected_length;
    modport source (output valid, output expected_length, input ready);
    modport sink   (input valid, input expected_length, output ready);
endinterface

@@ hdl/http_chunked_body_decoder.sv @@
// Chunked transfer body decoder top level with its line store memory.
// Depends on hcbd_pkg and the interfaces in hcbd_if.
//
// channel  dir  beat carries                          ready
// i_in     in   in_byte                               low while a line is scanned or a beat stalls
// o_out    out  data_valid, data_byte, status         from the sink
// i_cfg    in   expected_length                       always high
//
// A payload, CR, LF or ordinary line byte is one input beat; one output beat per input beat.
// A line end (LF) starts a scan of the line store: one read port of the store,
// one byte parsed per cycle; its beat leaves at scan end.
// Reset is synchronous; the line store is not cleared.
// A stalled output holds the beat and blocks input until taken.
module http_chunked_body_decoder #(
    parameter int LINE_BYTES   = hcbd_pkg::LINE_BYTES_DEF,
    parameter int MAX_TRAILERS = hcbd_pkg::MAX_TRAILERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcbd_in_if.sink           i_in,
    hcbd_out_if.source        o_out,
    hcbd_cfg_if.sink          i_cfg
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int TW = $clog2(MAX_TRAILERS + 2);
    localparam int LW = hcbd_pkg::LEN_W;
    localparam int BW = hcbd_pkg::BYTE_W;

    typedef enum logic [2:0] {
        P_LINE, P_DATA, P_DATA_CR, P_DATA_LF, P_TRAIL, P_DONE, P_FAIL, P_SCAN
    } t_phase;

    typedef enum logic [3:0] {
        X_H0, X_H1, X_A, X_AWS, X_SEMI, X_NAME, X_NWS, X_EQ, X_VAL, X_Q, X_QE,
        X_T0, X_T1, X_T2
    } t_pst;

    logic [BW-1:0] r_mem [LINE_BYTES];

    t_phase          r_phase, n_phase;
    t_pst            r_ps, n_ps;
    logic            r_cr, n_cr;
    logic            r_scan_trl, n_scan_trl;
    logic [AW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_left, n_left;
    logic [LW-1:0]   r_cnt, n_cnt;
    logic [LW-1:0]   r_exp;
    logic [TW-1:0]   r_trl, n_trl;
    logic [LW-1:0]   r_size, n_size;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_pos, n_pos;
    logic            r_dv, n_dv;
    logic [BW-1:0]   r_rd_data;
    logic            r_ov, n_ov;
    logic            r_odv, n_odv;
    logic [BW-1:0]   r_ob, n_ob;
    logic [hcbd_pkg::STAT_W-1:0] r_ost, n_ost;

    logic            w_acc, w_take, w_we, w_emit, w_fail;
    logic [BW-1:0]   w_c, w_ch;
    logic [4:0]      w_hex;
    logic [LW-1:0]   w_room;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_phase != P_SCAN) && (!r_ov || o_out.ready);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_take      = r_ov && o_out.ready;
    assign w_c         = i_in.in_byte;
    assign w_ch        = r_rd_data;
    assign w_hex       = hcbd_pkg::hex_val(w_ch);
    assign w_room      = r_exp - r_cnt;

    assign o_out.valid      = r_ov;
    assign o_out.data_valid = r_odv;
    assign o_out.data_byte  = r_ob;
    assign o_out.status     = r_ost;

    always_comb begin
        n_phase    = r_phase;
        n_ps       = r_ps;
        n_cr       = r_cr;
        n_scan_trl = r_scan_trl;
        n_len      = r_len;
        n_left     = r_left;
        n_cnt      = r_cnt;
        n_trl      = r_trl;
        n_size     = r_size;
        n_addr     = r_addr;
        n_pos      = r_pos;
        n_dv       = r_dv;
        n_odv      = 1'b0;
        n_ob       = '0;
        w_we       = 1'b0;
        w_emit     = 1'b0;
        w_fail     = 1'b0;

        if (w_acc) begin
            w_emit = 1'b1;
            case (r_phase)
                P_DATA: begin
                    n_odv  = 1'b1;
                    n_ob   = w_c;
                    n_left = r_left - LW'(1);
                    n_cnt  = r_cnt + LW'(1);
                    if (r_left == LW'(1)) begin
                        n_phase = P_DATA_CR;
                    end
                end
                P_DATA_CR: begin
                    n_phase = (w_c == hcbd_pkg::CHR_CR) ? P_DATA_LF : P_FAIL;
                end
                P_DATA_LF: begin
                    n_phase = (w_c == hcbd_pkg::CHR_LF) ? P_LINE : P_FAIL;
                end
                P_LINE, P_TRAIL: begin
                    if (r_cr) begin
                        n_cr = 1'b0;
                        if (w_c != hcbd_pkg::CHR_LF) begin
                            n_phase = P_FAIL;
                        end else if (r_phase == P_TRAIL && r_len == '0) begin
                            n_phase = (r_cnt == r_exp) ? P_DONE : P_FAIL;
                        end else if (r_phase == P_TRAIL && r_trl >= TW'(MAX_TRAILERS)) begin
                            n_phase = P_FAIL;
                        end else begin
                            w_emit     = 1'b0;
                            n_phase    = P_SCAN;
                            n_scan_trl = (r_phase == P_TRAIL);
                            n_ps       = (r_phase == P_TRAIL) ? X_T0 : X_H0;
                            n_size     = '0;
                            n_addr     = '0;
                            n_dv       = 1'b0;
                            if (r_phase == P_TRAIL) begin
                                n_trl = r_trl + TW'(1);
                            end
                        end
                    end else if (w_c == hcbd_pkg::CHR_CR) begin
                        n_cr = 1'b1;
                    end else if (hcbd_pkg::line_byte_bad(w_c) ||
                                 r_len == AW'(LINE_BYTES - 1)) begin
                        n_phase = P_FAIL;
                    end else begin
                        w_we  = 1'b1;
                        n_len = r_len + AW'(1);
                    end
                end
                P_DONE: ;
                P_FAIL: ;
                default: n_phase = P_FAIL;
            endcase
        end

        if (r_phase == P_SCAN) begin
            n_addr = r_addr + AW'(1);
            n_pos  = r_addr;
            n_dv   = 1'b1;
            if (r_dv && r_pos == r_len) begin
                w_emit = 1'b1;
                n_len  = '0;
                if (r_scan_trl) begin
                    n_phase = (r_ps == X_T2) ? P_TRAIL : P_FAIL;
                end else if (!(r_ps == X_H1 || r_ps == X_A || r_ps == X_NAME ||
                               r_ps == X_VAL)) begin
                    n_phase = P_FAIL;
                end else if (r_size == '0) begin
                    n_phase = P_TRAIL;
                end else if (r_cnt > r_exp || r_size > w_room) begin
                    n_phase = P_FAIL;
                end else begin
                    n_left  = r_size;
                    n_phase = P_DATA;
                end
            end else if (r_dv) begin
                case (r_ps)
                    X_H0, X_H1: begin
                        if (w_hex[4]) begin
                            if (r_size[LW-1:LW-4] != 4'd0) begin
                                w_fail = 1'b1;
                            end else begin
                                n_size = {r_size[LW-5:0], w_hex[3:0]};
                                n_ps   = X_H1;
                            end
                        end else if (r_ps == X_H0) begin
                            w_fail = 1'b1;
                        end else if (hcbd_pkg::is_ws(w_ch)) begin
                            n_ps = X_AWS;
                        end else if (w_ch == hcbd_pkg::CHR_SEMI) begin
                            n_ps = X_SEMI;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    X_A, X_AWS: begin
                        if (hcbd_pkg::is_ws(w_ch)) begin
                            n_ps = X_AWS;
                        end else if (w_ch == hcbd_pkg::CHR_SEMI) begin
                            n_ps = X_SEMI;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    X_SEMI: begin
                        if (hcbd_pkg::is_tok(w_ch)) begin
                            n_ps = X_NAME;
                        end else if (!hcbd_pkg::is_ws(w_ch)) begin
                            w_fail = 1'b1;
                        end
                    end
                    X_NAME, X_NWS: begin
                        if (r_ps == X_NAME && hcbd_pkg::is_tok(w_ch)) begin
                            n_ps = X_NAME;
                        end else if (hcbd_pkg::is_ws(w_ch)) begin
                            n_ps = X_NWS;
                        end else if (w_ch == hcbd_pkg::CHR_EQ) begin
                            n_ps = X_EQ;
                        end else if (w_ch == hcbd_pkg::CHR_SEMI) begin
                            n_ps = X_SEMI;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    X_EQ: begin
                        if (w_ch == hcbd_pkg::CHR_QUOTE) begin
                            n_ps = X_Q;
                        end else if (hcbd_pkg::is_tok(w_ch)) begin
                            n_ps = X_VAL;
                        end else if (!hcbd_pkg::is_ws(w_ch)) begin
                            w_fail = 1'b1;
                        end
                    end
                    X_VAL: begin
                        if (hcbd_pkg::is_tok(w_ch)) begin
                            n_ps = X_VAL;
                        end else if (hcbd_pkg::is_ws(w_ch)) begin
                            n_ps = X_AWS;
                        end else if (w_ch == hcbd_pkg::CHR_SEMI) begin
                            n_ps = X_SEMI;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    X_Q: begin
                        if (w_ch == hcbd_pkg::CHR_QUOTE) begin
                            n_ps = X_A;
                        end else if (w_ch == hcbd_pkg::CHR_BSLASH) begin
                            n_ps = X_QE;
                        end
                    end
                    X_QE: n_ps = X_Q;
                    X_T0: begin
                        if (hcbd_pkg::is_tok(w_ch)) begin
                            n_ps = X_T1;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    X_T1: begin
                        if (w_ch == hcbd_pkg::CHR_COLON) begin
                            n_ps = X_T2;
                        end else if (!hcbd_pkg::is_tok(w_ch)) begin
                            w_fail = 1'b1;
                        end
                    end
                    X_T2: ;
                    default: w_fail = 1'b1;
                endcase
                if (w_fail) begin
                    w_emit  = 1'b1;
                    n_phase = P_FAIL;
                end
            end
        end

        n_ost = (n_phase == P_FAIL) ? hcbd_pkg::ST_FAIL :
                (n_phase == P_DONE) ? hcbd_pkg::ST_DONE : hcbd_pkg::ST_MORE;
        n_ov  = w_emit ? 1'b1 : (w_take ? 1'b0 : r_ov);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_len] <= w_c;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= P_LINE;
            r_ps       <= X_H0;
            r_cr       <= 1'b0;
            r_scan_trl <= 1'b0;
            r_len      <= '0;
            r_left     <= '0;
            r_cnt      <= '0;
            r_exp      <= '0;
            r_trl      <= '0;
            r_addr     <= '0;
            r_pos      <= '0;
            r_dv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ps       <= n_ps;
            r_cr       <= n_cr;
            r_scan_trl <= n_scan_trl;
            r_len      <= n_len;
            r_left     <= n_left;
            r_cnt      <= n_cnt;
            r_trl      <= n_trl;
            r_addr     <= n_addr;
            r_pos      <= n_pos;
            r_dv       <= n_dv;
            r_ov       <= n_ov;
            if (i_cfg.valid) begin
                r_exp <= i_cfg.expected_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        if (w_emit) begin
            r_odv <= n_odv;
            r_ob  <= n_ob;
            r_ost <= n_ost;
        end
    end

endmodule

@@ hdl/hcbd_chk.sv @@
// Port-level checker of the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder_defines.svh.
`include "http_chunked_body_decoder_defines.svh"

module hcbd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_data_valid,
    input logic [hcbd_pkg::BYTE_W-1:0] i_data_byte,
    input logic [hcbd_pkg::STAT_W-1:0] i_status
);

    logic       r_fail_seen;
    logic [1:0] r_outst;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_seen <= 1'b0;
            r_outst     <= '0;
        end else begin
            if (w_out_acc && i_status == hcbd_pkg::ST_FAIL) begin
                r_fail_seen <= 1'b1;
            end
            r_outst <= r_outst + 2'(w_in_acc) - 2'(w_out_acc);
        end
    end

    `HCBD_ASSERT_IMP(a_no_orphan_beat, w_out_acc, r_outst != 2'd0, "output beat without input")
    `HCBD_ASSERT_IMP(a_data_status, i_out_valid && i_data_valid, i_status == hcbd_pkg::ST_MORE, "payload with final status")
    `HCBD_ASSERT_IMP(a_idle_byte, i_out_valid && !i_data_valid, i_data_byte == '0, "idle beat carries a byte")
    `HCBD_ASSERT_IMP(a_fail_sticky, r_fail_seen && w_out_acc, i_status == hcbd_pkg::ST_FAIL, "failure not sticky")

endmodule

bind http_chunked_body_decoder hcbd_chk u_hcbd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_valid (o_out.data_valid),
    .i_data_byte  (o_out.data_byte),
    .i_status     (o_out.status)
);

@@ bench/http_chunked_body_decoder_tb.sv @@
// Self-checking bench for http_chunked_body_decoder: drives one chunked body
// byte by byte, predicts every output beat and compares. Depends on hcbd_pkg and hcbd_if.
`timescale 1ns / 1ps
module http_chunked_body_decoder_tb;

    localparam int LINE_MAX = hcbd_pkg::LINE_BYTES_DEF;
    localparam longint unsigned LEN_MAX = 64'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        PH_SIZE, PH_DATA, PH_DATA_CR, PH_DATA_LF, PH_TRAILER, PH_DONE, PH_FAILED
    } t_parse_phase;

    typedef struct packed {
        logic                        data_valid;
        logic [hcbd_pkg::BYTE_W-1:0] data_byte;
        logic [hcbd_pkg::STAT_W-1:0] status;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();
    hcbd_cfg_if cfg_ch ();

    http_chunked_body_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // decoder shadow state
    t_parse_phase     phase;
    logic             saw_cr;
    logic [7:0]       line_buf [LINE_MAX];
    int unsigned      line_len;
    longint unsigned  chunk_left, decoded, body_len;
    int unsigned      trailers;

    t_beat  expected_beats [$];
    int     errors = 0;
    bit     calm = 0;
    int     hold_cycles = 0;
    int     stall = 0;

    function automatic int unsigned ch_at(int unsigned i);
        return (i < line_len) ? line_buf[i] : 0;
    endfunction

    function automatic int hex_of(int unsigned c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic bit tok_char(int unsigned c);
        return (c != 0) && hcbd_pkg::is_tok(c[7:0]);
    endfunction

    function automatic bit ws_char(int unsigned c);
        return (c == 32) || (c == 9);
    endfunction

    function automatic bit extensions_ok(int unsigned i);
        int unsigned start, nm, eq, v, c, e;
        bit closed;
        forever begin
            start = i;
            while (ws_char(ch_at(i))) i++;
            if (ch_at(i) != hcbd_pkg::CHR_SEMI) return (i == start) && (ch_at(i) == 0);
            i++;
            while (ws_char(ch_at(i))) i++;
            nm = i;
            while (tok_char(ch_at(i))) i++;
            if (i == nm) return 0;
            eq = i;
            while (ws_char(ch_at(eq))) eq++;
            if (ch_at(eq) != hcbd_pkg::CHR_EQ) continue;
            i = eq + 1;
            while (ws_char(ch_at(i))) i++;
            if (ch_at(i) == hcbd_pkg::CHR_QUOTE) begin
                closed = 0;
                i++;
                while (ch_at(i) != 0) begin
                    c = ch_at(i);
                    i++;
                    if (c == hcbd_pkg::CHR_QUOTE) begin
                        closed = 1;
                        break;
                    end
                    if (c == hcbd_pkg::CHR_BSLASH) begin
                        e = ch_at(i);
                        i++;
                        if (e == 0 || (e != 9 && (e < 32 || e == 127))) return 0;
                    end else if (!(c == 9 || c == 32 || c == 33 || (c >= 35 && c <= 91) ||
                                   (c >= 93 && c <= 126) || c >= 128)) begin
                        return 0;
                    end
                end
                if (!closed) return 0;
            end else begin
                v = i;
                while (tok_char(ch_at(i))) i++;
                if (i == v) return 0;
            end
        end
    endfunction

    function automatic bit trailer_line_ok();
        int unsigned colon, i, c;
        colon = 0;
        while (colon < line_len && ch_at(colon) != hcbd_pkg::CHR_COLON) colon++;
        if (colon >= line_len || colon == 0) return 0;
        for (i = 0; i < colon; i++) if (!tok_char(ch_at(i))) return 0;
        for (i = colon + 1; i < line_len; i++) begin
            c = ch_at(i);
            if ((c < 32 && c != 9) || c == 127) return 0;
        end
        return 1;
    endfunction

    function automatic void close_line();
        int unsigned i;
        longint unsigned sz;
        int d;
        if (phase == PH_TRAILER) begin
            if (line_len == 0) begin
                phase = (decoded == body_len) ? PH_DONE : PH_FAILED;
                return;
            end
            trailers++;
            if (trailers > hcbd_pkg::MAX_TRAILERS_DEF || !trailer_line_ok()) begin
                phase = PH_FAILED;
                return;
            end
            line_len = 0;
            return;
        end
        i = 0;
        sz = 0;
        d = hex_of(ch_at(0));
        while (d >= 0) begin
            if (sz > (LEN_MAX - d) / 16) begin
                phase = PH_FAILED;
                return;
            end
            sz = sz * 16 + d;
            i++;
            d = hex_of(ch_at(i));
        end
        if (i == 0 || !extensions_ok(i)) begin
            phase = PH_FAILED;
            return;
        end
        line_len = 0;
        if (sz == 0) begin
            phase = PH_TRAILER;
        end else if (decoded > body_len || sz > body_len - decoded) begin
            phase = PH_FAILED;
        end else begin
            chunk_left = sz;
            phase = PH_DATA;
        end
    endfunction

    function automatic t_beat decode_byte(logic [7:0] c);
        t_beat r;
        r = '0;
        case (phase)
            PH_DATA: begin
                r.data_valid = 1;
                r.data_byte = c;
                chunk_left = (chunk_left - 1) & LEN_MAX;
                decoded = (decoded + 1) & LEN_MAX;
                if (chunk_left == 0) phase = PH_DATA_CR;
            end
            PH_DATA_CR: phase = (c == hcbd_pkg::CHR_CR) ? PH_DATA_LF : PH_FAILED;
            PH_DATA_LF: phase = (c == hcbd_pkg::CHR_LF) ? PH_SIZE : PH_FAILED;
            PH_SIZE, PH_TRAILER: begin
                if (saw_cr) begin
                    if (c != hcbd_pkg::CHR_LF) begin
                        phase = PH_FAILED;
                    end else begin
                        saw_cr = 0;
                        close_line();
                    end
                end else if (c == hcbd_pkg::CHR_CR) begin
                    saw_cr = 1;
                end else if (hcbd_pkg::line_byte_bad(c) || line_len + 1 >= LINE_MAX) begin
                    phase = PH_FAILED;
                end else begin
                    line_buf[line_len] = c;
                    line_len++;
                end
            end
            PH_DONE: ;
            default: phase = PH_FAILED;
        endcase
        r.status = (phase == PH_FAILED) ? hcbd_pkg::ST_FAIL :
                   (phase == PH_DONE) ? hcbd_pkg::ST_DONE : hcbd_pkg::ST_MORE;
        return r;
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_beats.push_back(decode_byte(b));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_beats.size() > 0) @(posedge i_clk);
        repeat (LINE_MAX + 4) @(posedge i_clk);
    endtask

    task automatic write_length(longint unsigned v);
        drain();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.expected_length <= v[hcbd_pkg::LEN_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        body_len = v & LEN_MAX;
    endtask

    // size line with random case, leading zeros and the odd extension
    task automatic send_chunk(int unsigned n);
        string line, dig;
        line = "";
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) line = {line, "0"};
        dig = ($urandom_range(0, 1)) ? $sformatf("%h", n) : $sformatf("%H", n);
        while (dig.len() > 1 && dig[0] == "0") dig = dig.substr(1, dig.len() - 1);
        line = {line, dig};
        case ($urandom_range(0, 5))
            0: line = {line, ";ext"};
            1: line = {line, " ; k-1 = v.x"};
            2: line = {line, ";q=\"a b\\\"c\";z"};
            default: ;
        endcase
        send_text({line, "\r\n"});
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        send_text("\r\n");
    endtask

    task automatic test_directed();
        write_length(0);
        write_length(LEN_MAX);
        send_text("2\t;\tn=\"\t~\\\"\"\r\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\r\n");
        send_text("1;a\r\n");
        send_byte(8'h5A);
        send_text("\r\n");
    endtask

    task automatic test_random_chunks(int unsigned budget);
        int unsigned n;
        while (budget > 0) begin
            if ($urandom_range(0, 7) == 0) calm = ~calm;
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            send_chunk(n);
            budget = (budget > n + 8) ? budget - n - 8 : 0;
        end
        calm = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        test_random_chunks(120);
        drain();
        test_random_chunks(80);
    endtask

    task automatic test_trailers_and_end();
        send_text("0;last\r\n");
        send_text("Host: x\r\n");
        send_text("X-t:\tv w\r\n");
        write_length(decoded);
        send_text("\r\n");
    endtask

    task automatic test_after_end();
        repeat (30) send_byte(8'($urandom_range(0, 255)));
        write_length(0);
        repeat (10) send_byte(8'($urandom_range(0, 255)));
    endtask

    always @(posedge i_clk) begin
        t_beat got, exp_b;
        if (out_ch.valid && out_ch.ready) begin
            got = {out_ch.data_valid, out_ch.data_byte, out_ch.status};
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h", $realtime, got);
                errors++;
            end else begin
                exp_b = expected_beats.pop_front();
                if (got.data_valid !== exp_b.data_valid ||
                    got.status !== exp_b.status ||
                    (exp_b.data_valid && got.data_byte !== exp_b.data_byte)) begin
                    $display("%0t beat mismatch: expected dv=%b byte=%h st=%0d, %s",
                             $realtime, exp_b.data_valid, exp_b.data_byte, exp_b.status,
                             $sformatf("actual dv=%b byte=%h st=%0d",
                                       got.data_valid, got.data_byte, got.status));
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic nxt;
        if (!i_rst_n) begin
            nxt = 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            nxt = 1'b0;
        end else if (stall > 0) begin
            stall--;
            nxt = 1'b0;
        end else begin
            nxt = 1'b1;
            if (out_ch.valid && out_ch.ready && !calm) begin
                stall = $urandom_range(0, 7);
                nxt = (stall == 0);
            end
        end
        out_ch.ready <= nxt;
    end

    initial begin
        in_ch.valid            <= 1'b0;
        in_ch.in_byte          <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.expected_length <= '0;
        phase      = PH_SIZE;
        saw_cr     = 0;
        line_len   = 0;
        chunk_left = 0;
        decoded    = 0;
        body_len   = 0;
        trailers   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_chunks(700);
        test_backpressure();
        test_random_chunks(500);
        test_trailers_and_end();
        test_after_end();
        drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
